// File: src/sphm_pkg.sv
package sphm_pkg;

  localparam int TIME_BITS     = 32;
  localparam int ERR_BITS      = 16;
  localparam int PCT_BITS      = 7;
  localparam int WIN_BITS      = 16;
  localparam int DROP_CNT_BITS = 16;
  localparam int STAB_BITS     = 14;
  localparam int HEALTH_BITS   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [STAB_BITS-1:0] STAB_SCALE = 14'd10000;
  localparam logic [PCT_BITS-1:0]  DROP_SCALE = 7'd100;

  localparam logic [PCT_BITS-1:0] PCT_RESET      = 7'd10;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET   = 16'd1000;
  localparam logic [WIN_BITS-1:0] MARGINAL_RESET = 16'd5;
  localparam logic [WIN_BITS-1:0] GRACE_RESET    = 16'd1000;

  localparam logic [CFG_IDX_BITS-1:0] REG_DROP_PCT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGINAL  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRACE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_EN   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_JUDGE,
    ST_CORR,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [HEALTH_BITS-1:0] {
    HEALTH_OK       = 2'd0,
    HEALTH_MARGINAL = 2'd1,
    HEALTH_UNSTABLE = 2'd2,
    HEALTH_FAILED   = 2'd3
  } health_t;

endpackage

// File: src/supply_power_health_monitor.sv
// Supply power health monitor. Each request is one poll sample (timestamp, two power
// readings, two cumulative error counts, two load-running flags; tuser carries the
// session clear flag) and yields exactly one result: total power, drop count, largest
// drop, sticky error correlation flag, stability in hundredths of a percent, health code
// and stop request. After a sample is accepted the block is not ready again until its
// result is finished. Stability is recomputed only once two nonzero samples have been
// accumulated; the divider is skipped when the power spread is so large that stability
// clamps to zero. The recomputation is the bit-serial product of power spread and
// sample count, one count bit per cycle, followed by a 14-step scaling by 10000 and a
// 14-step restoring divider by the power sum. A finished result waits in the output
// register while the next sample is accepted; the block only holds a second result back
// until the first has been taken.
module supply_power_health_monitor #(
  parameter int POWER_BITS = 20,
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  // tdata, from bit 0: time_ms, cpu_power_mw, gpu_power_mw, cpu_errors, gpu_errors,
  // cpu_active, gpu_active, zero fill.
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((sphm_pkg::TIME_BITS + 2*POWER_BITS + 2*sphm_pkg::ERR_BITS + 2 + 7)
                 / 8) * 8 - 1 : 0] s_tdata,
  // tuser: clear.
  input  logic s_tuser,
  // tdata, from bit 0: total_power_mw, drop_events, largest_drop_mw, errors_correlated,
  // stability_centi_pct, health, stop_request, zero fill.
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2*(POWER_BITS + 1) + sphm_pkg::DROP_CNT_BITS + 1 + sphm_pkg::STAB_BITS
                  + sphm_pkg::HEALTH_BITS + 1 + 7) / 8) * 8 - 1 : 0] m_tdata,
  input  logic cfg_wr_en,
  input  logic [sphm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [sphm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int TOTAL_BITS = POWER_BITS + 1;
  localparam int PROD_BITS  = TOTAL_BITS + COUNT_BITS;
  localparam int SUM_BITS   = (PROD_BITS > 64) ? 64 : PROD_BITS;
  localparam int SUM_EXT    = SUM_BITS + 1;
  localparam int NUM_BITS   = PROD_BITS + sphm_pkg::STAB_BITS;
  localparam int CMP_BITS   = TOTAL_BITS + sphm_pkg::PCT_BITS;
  localparam int ETOT_BITS  = sphm_pkg::ERR_BITS + 1;
  localparam int STEP_MAX   = (COUNT_BITS > sphm_pkg::STAB_BITS) ? COUNT_BITS
                                                                   : sphm_pkg::STAB_BITS;
  localparam int STEP_BITS  = $clog2(STEP_MAX);
  localparam int SIDX_BITS  = $clog2(sphm_pkg::STAB_BITS);
  localparam int OUT_W      = $bits(m_tdata);

  localparam int OFF_CPU_P = sphm_pkg::TIME_BITS;
  localparam int OFF_GPU_P = OFF_CPU_P + POWER_BITS;
  localparam int OFF_CPU_E = OFF_GPU_P + POWER_BITS;
  localparam int OFF_GPU_E = OFF_CPU_E + sphm_pkg::ERR_BITS;
  localparam int OFF_CPU_A = OFF_GPU_E + sphm_pkg::ERR_BITS;
  localparam int OFF_GPU_A = OFF_CPU_A + 1;

  localparam int O_DROPS   = TOTAL_BITS;
  localparam int O_LARGEST = O_DROPS + sphm_pkg::DROP_CNT_BITS;
  localparam int O_CORR    = O_LARGEST + TOTAL_BITS;
  localparam int O_STAB    = O_CORR + 1;
  localparam int O_HEALTH  = O_STAB + sphm_pkg::STAB_BITS;
  localparam int O_STOP    = O_HEALTH + sphm_pkg::HEALTH_BITS;

  sphm_pkg::state_t state, state_next;

  logic [sphm_pkg::PCT_BITS-1:0] r_drop_pct;
  logic [sphm_pkg::WIN_BITS-1:0] r_window;
  logic [sphm_pkg::WIN_BITS-1:0] r_marginal;
  logic [sphm_pkg::WIN_BITS-1:0] r_grace;
  logic                          r_stop_en;

  logic [TOTAL_BITS-1:0]              previous_power;
  logic [ETOT_BITS-1:0]               previous_error_total;
  logic [SUM_BITS-1:0]                power_sum;
  logic [COUNT_BITS-1:0]              sample_count;
  logic [TOTAL_BITS-1:0]              power_minimum;
  logic [TOTAL_BITS-1:0]              power_maximum;
  logic                               recent_drop;
  logic [sphm_pkg::TIME_BITS-1:0]     last_drop_time;
  logic [sphm_pkg::DROP_CNT_BITS-1:0] drop_counter;
  logic [TOTAL_BITS-1:0]              largest_drop;
  logic                               correlated_flag;
  logic [sphm_pkg::STAB_BITS-1:0]     stability_value;

  logic                           clear_q;
  logic [sphm_pkg::TIME_BITS-1:0] now_q;
  logic [TOTAL_BITS-1:0]          total_q;
  logic [ETOT_BITS-1:0]           err_total_q;
  logic                           cpu_act_q;
  logic                           gpu_act_q;
  logic                           err_any_q;

  logic                           drop_cand;
  logic [TOTAL_BITS-1:0]          drop_amt;
  logic [CMP_BITS-1:0]            drop_x100;
  logic [CMP_BITS-1:0]            pct_prev;
  sphm_pkg::health_t              health_q;

  logic [PROD_BITS-1:0]           prod;
  logic [COUNT_BITS-1:0]          mplier;
  logic [NUM_BITS-1:0]            acc;
  logic [SUM_BITS-1:0]            rem;
  logic [sphm_pkg::STAB_BITS-1:0] quot;
  logic [STEP_BITS-1:0]           cnt;

  logic [SUM_BITS-1:0]            base_sum;
  logic [COUNT_BITS-1:0]          base_cnt;
  logic [TOTAL_BITS-1:0]          base_min;
  logic [TOTAL_BITS-1:0]          base_max;
  logic [TOTAL_BITS-1:0]          base_prev;
  logic [SUM_EXT-1:0]             sum_add;
  logic [TOTAL_BITS-1:0]          drop_diff;
  logic [sphm_pkg::TIME_BITS-1:0] since;
  logic                           corr_hit;
  logic                           corr_next;
  logic [TOTAL_BITS-1:0]          spread;
  logic [NUM_BITS-1:0]            acc_next;
  logic                           zero_case;
  logic [SUM_EXT-1:0]             div_t;
  logic                           div_ge;
  logic [SUM_EXT-1:0]             div_diff;
  logic [sphm_pkg::STAB_BITS-1:0] quot_next;
  logic                           stab_go;
  logic                           out_free;
  logic [OUT_W-1:0]               out_word;
  sphm_pkg::health_t              health_calc;

  assign s_tready = (state == sphm_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_drop_pct <= sphm_pkg::PCT_RESET;
      r_window   <= sphm_pkg::WINDOW_RESET;
      r_marginal <= sphm_pkg::MARGINAL_RESET;
      r_grace    <= sphm_pkg::GRACE_RESET;
      r_stop_en  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sphm_pkg::REG_DROP_PCT: r_drop_pct <= cfg_data[sphm_pkg::PCT_BITS-1:0];
        sphm_pkg::REG_WINDOW:   r_window   <= cfg_data[sphm_pkg::WIN_BITS-1:0];
        sphm_pkg::REG_MARGINAL: r_marginal <= cfg_data[sphm_pkg::WIN_BITS-1:0];
        sphm_pkg::REG_GRACE:    r_grace    <= cfg_data[sphm_pkg::WIN_BITS-1:0];
        sphm_pkg::REG_STOP_EN:  r_stop_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_sum  = clear_q ? '0 : power_sum;
    base_cnt  = clear_q ? '0 : sample_count;
    base_min  = clear_q ? '1 : power_minimum;
    base_max  = clear_q ? '0 : power_maximum;
    base_prev = clear_q ? '0 : previous_power;
    sum_add   = {1'b0, base_sum} + SUM_EXT'(total_q);
    drop_diff = base_prev - total_q;

    since     = now_q - last_drop_time;
    corr_hit  = recent_drop && (err_total_q > previous_error_total)
                && (since <= sphm_pkg::TIME_BITS'(r_window));
    corr_next = correlated_flag || corr_hit;
    stab_go   = (sample_count > COUNT_BITS'(1)) && (power_sum != '0);

    if (!cpu_act_q && !gpu_act_q && (now_q > sphm_pkg::TIME_BITS'(r_grace))) begin
      health_calc = sphm_pkg::HEALTH_FAILED;
    end else if (corr_next) begin
      health_calc = sphm_pkg::HEALTH_UNSTABLE;
    end else if (drop_counter > r_marginal) begin
      health_calc = sphm_pkg::HEALTH_MARGINAL;
    end else begin
      health_calc = sphm_pkg::HEALTH_OK;
    end

    spread    = power_maximum - power_minimum;
    acc_next  = (acc << 1)
                + (sphm_pkg::STAB_SCALE[cnt[SIDX_BITS-1:0]] ? NUM_BITS'(prod) : '0);
    zero_case = PROD_BITS'(power_sum) <= prod;
    div_t     = {rem, acc[sphm_pkg::STAB_BITS-1]};
    div_ge    = div_t >= SUM_EXT'(power_sum);
    div_diff  = div_t - SUM_EXT'(power_sum);
    quot_next = {quot[sphm_pkg::STAB_BITS-2:0], div_ge};

    out_word = '0;
    out_word[0 +: TOTAL_BITS] = total_q;
    out_word[O_DROPS +: sphm_pkg::DROP_CNT_BITS] = drop_counter;
    out_word[O_LARGEST +: TOTAL_BITS] = largest_drop;
    out_word[O_CORR] = correlated_flag;
    out_word[O_STAB +: sphm_pkg::STAB_BITS] = stability_value;
    out_word[O_HEALTH +: sphm_pkg::HEALTH_BITS] = sphm_pkg::HEALTH_BITS'(health_q);
    out_word[O_STOP] = r_stop_en && err_any_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sphm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sphm_pkg::ST_IDLE:   if (s_tvalid) state_next = sphm_pkg::ST_UPDATE;
      sphm_pkg::ST_UPDATE: state_next = sphm_pkg::ST_JUDGE;
      sphm_pkg::ST_JUDGE:  state_next = sphm_pkg::ST_CORR;
      sphm_pkg::ST_CORR:   state_next = stab_go ? sphm_pkg::ST_MUL : sphm_pkg::ST_DONE;
      sphm_pkg::ST_MUL:    if (cnt == '0) state_next = sphm_pkg::ST_SCALE;
      sphm_pkg::ST_SCALE: begin
        if (cnt == '0) begin
          state_next = zero_case ? sphm_pkg::ST_DONE : sphm_pkg::ST_DIV;
        end
      end
      sphm_pkg::ST_DIV:    if (cnt == '0) state_next = sphm_pkg::ST_DONE;
      sphm_pkg::ST_DONE:   if (out_free) state_next = sphm_pkg::ST_IDLE;
      default:             state_next = sphm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == sphm_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sphm_pkg::ST_DONE && out_free) begin
      m_tdata <= out_word;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      clear_q     <= s_tuser;
      now_q       <= s_tdata[0 +: sphm_pkg::TIME_BITS];
      total_q     <= TOTAL_BITS'(s_tdata[OFF_CPU_P +: POWER_BITS])
                     + TOTAL_BITS'(s_tdata[OFF_GPU_P +: POWER_BITS]);
      err_total_q <= ETOT_BITS'(s_tdata[OFF_CPU_E +: sphm_pkg::ERR_BITS])
                     + ETOT_BITS'(s_tdata[OFF_GPU_E +: sphm_pkg::ERR_BITS]);
      err_any_q   <= (s_tdata[OFF_CPU_E +: sphm_pkg::ERR_BITS] != '0)
                     || (s_tdata[OFF_GPU_E +: sphm_pkg::ERR_BITS] != '0);
      cpu_act_q   <= s_tdata[OFF_CPU_A];
      gpu_act_q   <= s_tdata[OFF_GPU_A];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sphm_pkg::ST_UPDATE: begin
        drop_cand <= (base_prev != '0) && (total_q != '0) && (base_prev > total_q);
        drop_amt  <= drop_diff;
        drop_x100 <= CMP_BITS'(drop_diff) * CMP_BITS'(sphm_pkg::DROP_SCALE);
        pct_prev  <= CMP_BITS'(r_drop_pct) * CMP_BITS'(base_prev);
      end
      sphm_pkg::ST_CORR: begin
        health_q <= health_calc;
        prod     <= '0;
        mplier   <= sample_count;
        cnt      <= STEP_BITS'(COUNT_BITS - 1);
      end
      sphm_pkg::ST_MUL: begin
        prod   <= (prod << 1) + (mplier[COUNT_BITS-1] ? PROD_BITS'(spread) : '0);
        mplier <= mplier << 1;
        if (cnt == '0) begin
          acc <= '0;
          cnt <= STEP_BITS'(sphm_pkg::STAB_BITS - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      sphm_pkg::ST_SCALE: begin
        acc <= acc_next;
        if (cnt == '0) begin
          rem <= acc_next[sphm_pkg::STAB_BITS +: SUM_BITS];
          cnt <= STEP_BITS'(sphm_pkg::STAB_BITS - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      sphm_pkg::ST_DIV: begin
        rem  <= div_ge ? div_diff[SUM_BITS-1:0] : div_t[SUM_BITS-1:0];
        quot <= quot_next;
        acc  <= acc << 1;
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_power       <= '0;
      previous_error_total <= '0;
      power_sum            <= '0;
      sample_count         <= '0;
      power_minimum        <= '1;
      power_maximum        <= '0;
      recent_drop          <= 1'b0;
      last_drop_time       <= '0;
      drop_counter         <= '0;
      largest_drop         <= '0;
      correlated_flag      <= 1'b0;
      stability_value      <= '0;
    end else begin
      case (state)
        sphm_pkg::ST_UPDATE: begin
          if (total_q != '0 && base_cnt != '1) begin
            power_sum    <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
            sample_count <= base_cnt + 1'b1;
          end else begin
            power_sum    <= base_sum;
            sample_count <= base_cnt;
          end
          if (total_q != '0 && total_q < base_min) begin
            power_minimum <= total_q;
          end else begin
            power_minimum <= base_min;
          end
          if (total_q != '0 && total_q > base_max) begin
            power_maximum <= total_q;
          end else begin
            power_maximum <= base_max;
          end
          previous_power <= base_prev;
          if (clear_q) begin
            previous_error_total <= '0;
            recent_drop          <= 1'b0;
            last_drop_time       <= '0;
            drop_counter         <= '0;
            largest_drop         <= '0;
            correlated_flag      <= 1'b0;
            stability_value      <= '0;
          end
        end
        sphm_pkg::ST_JUDGE: begin
          if (drop_cand && drop_x100 > pct_prev) begin
            if (drop_counter != '1) begin
              drop_counter <= drop_counter + 1'b1;
            end
            last_drop_time <= now_q;
            recent_drop    <= 1'b1;
            if (drop_amt > largest_drop) begin
              largest_drop <= drop_amt;
            end
          end
          previous_power <= total_q;
        end
        sphm_pkg::ST_CORR: begin
          correlated_flag <= corr_next;
          if (recent_drop && since > sphm_pkg::TIME_BITS'(r_window)) begin
            recent_drop <= 1'b0;
          end
          previous_error_total <= err_total_q;
        end
        sphm_pkg::ST_SCALE: begin
          if (cnt == '0 && zero_case) begin
            stability_value <= '0;
          end
        end
        sphm_pkg::ST_DIV: begin
          if (cnt == '0) begin
            stability_value <= sphm_pkg::STAB_SCALE - quot_next;
          end
        end
        default: ;
      endcase
    end
  end

  a_stab_range: assert property (@(posedge clk) disable iff (rst)
    stability_value <= sphm_pkg::STAB_SCALE)
    else $error("stability above full scale");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == sphm_pkg::ST_DIV |-> rem < power_sum)
    else $error("divider remainder not below divisor");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    sample_count != '0 |-> power_minimum <= power_maximum)
    else $error("power minimum above maximum");

  a_drop_mono: assert property (@(posedge clk) disable iff (rst)
    state == sphm_pkg::ST_JUDGE |=> drop_counter >= $past(drop_counter))
    else $error("drop counter went down");

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        clear;
    logic [31:0] time_ms;
    logic [19:0] cpu_power_mw;
    logic [19:0] gpu_power_mw;
    logic [15:0] cpu_errors;
    logic [15:0] gpu_errors;
    logic        cpu_active;
    logic        gpu_active;
  } sample_t;

  typedef struct packed {
    logic [20:0]       total_power_mw;
    logic [15:0]       drop_events;
    logic [20:0]       largest_drop_mw;
    logic              errors_correlated;
    logic [13:0]       stability_centi_pct;
    sphm_pkg::health_t health;
    logic              stop_request;
  } status_t;

  typedef struct packed {
    sample_t smp;
    logic    known;
    status_t want;
  } row_t;

  localparam int IN_W = 112;
  localparam int OUT_W = 80;
  localparam int N_ROWS = 25;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 117;
  localparam logic [31:0] COUNT_MAX = 32'h00FF_FFFF;
  localparam status_t UNCHECKED = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [sphm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [sphm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  supply_power_health_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies and session state of the health predictor.
  logic [6:0]  pct_cfg;
  logic [15:0] window_cfg;
  logic [15:0] marginal_cfg;
  logic [15:0] grace_cfg;
  logic        stop_cfg;

  logic [20:0] last_total;
  logic [16:0] last_err_sum;
  logic [63:0] power_acc;
  logic [31:0] sample_cnt;
  logic [20:0] floor_mw;
  logic [20:0] peak_mw;
  logic        drop_live;
  logic [31:0] drop_time;
  logic [15:0] drop_cnt;
  logic [20:0] worst_drop;
  logic        corr_seen;
  logic [13:0] stab_hold;

  status_t pending_status[$];
  int fail_count = 0;
  bit calm = 1'b0;

  sample_t cur_sample = '0;
  logic    cur_known = 1'b0;
  status_t cur_want = '0;

  logic [31:0] sess_time;
  int unsigned sess_base_cpu;
  int unsigned sess_base_gpu;
  logic [15:0] sess_cpu_err;
  logic [15:0] sess_gpu_err;

  logic [15:0] settings [PHASES][5] = '{
    '{16'd10,  16'd1000,  16'd5,     16'd1000,  16'd0},
    '{16'd0,   16'd0,     16'd0,     16'd0,     16'd1},
    '{16'd100, 16'd65535, 16'd65535, 16'd65535, 16'd0},
    '{16'd99,  16'd50,    16'd2,     16'd300,   16'd1},
    '{16'd0,   16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd25,  16'd5000,  16'd10,    16'd2000,  16'd1}
  };

  // Every row runs with the register values present after reset.
  row_t directed [N_ROWS] = '{
    '{'{0, 0, 0, 0, 0, 0, 1, 1}, 1, '{0, 0, 0, 0, 0, sphm_pkg::HEALTH_OK, 0}},
    '{'{0, 100, 20'hFFFFF, 20'hFFFFF, 0, 0, 1, 1}, 1,
      '{2097150, 0, 0, 0, 0, sphm_pkg::HEALTH_OK, 0}},
    '{'{0, 200, 0, 1, 0, 0, 1, 1}, 1, '{1, 1, 2097149, 0, 0, sphm_pkg::HEALTH_OK, 0}},
    '{'{0, 300, 0, 1, 1, 0, 1, 1}, 1,
      '{1, 1, 2097149, 1, 0, sphm_pkg::HEALTH_UNSTABLE, 0}},
    '{'{1, 0, 1000, 1000, 0, 0, 0, 0}, 1, '{2000, 0, 0, 0, 0, sphm_pkg::HEALTH_OK, 0}},
    '{'{0, 1000, 1000, 1000, 0, 0, 0, 0}, 1,
      '{2000, 0, 0, 0, 10000, sphm_pkg::HEALTH_OK, 0}},
    '{'{0, 1001, 1000, 1000, 0, 0, 0, 0}, 1,
      '{2000, 0, 0, 0, 10000, sphm_pkg::HEALTH_FAILED, 0}},
    '{'{0, 1100, 900, 900, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 1200, 900, 899, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 1300, 800, 800, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 1300, 0, 0, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 1400, 100, 100, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 2401, 100, 100, 5, 5, 1, 1}, 0, UNCHECKED},
    '{'{1, 32'hFFFF_FF00, 50000, 50000, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 32'hFFFF_FFF0, 1000, 1000, 0, 0, 1, 1}, 0, UNCHECKED},
    '{'{0, 32'h0000_0100, 1000, 1000, 16'hFFFF, 16'hFFFF, 1, 1}, 0, UNCHECKED},
    '{'{0, 32'h0000_0200, 20'hFFFFF, 0, 16'hFFFF, 16'hFFFF, 1, 0}, 0, UNCHECKED},
    '{'{0, 32'h0000_0300, 0, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 0, 1}, 0, UNCHECKED},
    '{'{0, 32'hFFFF_FFFF, 1000, 0, 0, 0, 0, 0}, 0, UNCHECKED},
    '{'{1, 10, 20'h55555, 20'hAAAAA, 16'h5555, 16'hAAAA, 1, 1}, 0, UNCHECKED},
    '{'{0, 20, 20'hAAAAA, 20'h55555, 16'hAAAA, 16'h5555, 1, 0}, 0, UNCHECKED},
    '{'{0, 30, 1, 0, 16'hAAAA, 16'h5555, 0, 1}, 0, UNCHECKED},
    '{'{0, 40, 0, 0, 16'hAAAB, 16'h5555, 1, 1}, 0, UNCHECKED},
    '{'{0, 50, 20'hFFFFF, 20'hFFFFF, 16'hAAAB, 16'h5555, 1, 1}, 0, UNCHECKED},
    '{'{0, 60, 20'hFFFFF, 20'hFFFFE, 16'hAAAB, 16'h5556, 1, 1}, 0, UNCHECKED}
  };

  task automatic clear_session();
    last_total = '0;
    last_err_sum = '0;
    power_acc = '0;
    sample_cnt = '0;
    floor_mw = '1;
    peak_mw = '0;
    drop_live = 1'b0;
    drop_time = '0;
    drop_cnt = '0;
    worst_drop = '0;
    corr_seen = 1'b0;
    stab_hold = '0;
  endtask

  task automatic judge_sample(input sample_t s, output status_t r);
    logic [20:0]  total;
    logic [16:0]  err_sum;
    logic [20:0]  fall;
    logic [31:0]  since;
    logic [127:0] spread;
    logic [127:0] budget;
    total = 21'(s.cpu_power_mw) + 21'(s.gpu_power_mw);
    err_sum = 17'(s.cpu_errors) + 17'(s.gpu_errors);
    if (s.clear) clear_session();
    if (total != 0) begin
      if (sample_cnt < COUNT_MAX) begin
        power_acc = power_acc + 64'(total);
        sample_cnt = sample_cnt + 1;
      end
      if (total < floor_mw) floor_mw = total;
      if (total > peak_mw) peak_mw = total;
    end
    if (last_total != 0 && total != 0 && last_total > total) begin
      fall = last_total - total;
      if (64'(fall) * 64'd100 > 64'(pct_cfg) * 64'(last_total)) begin
        if (drop_cnt != 16'hFFFF) drop_cnt = drop_cnt + 1;
        drop_time = s.time_ms;
        drop_live = 1'b1;
        if (fall > worst_drop) worst_drop = fall;
      end
    end
    since = s.time_ms - drop_time;
    if (drop_live && err_sum > last_err_sum && since <= 32'(window_cfg)) corr_seen = 1'b1;
    if (drop_live && since > 32'(window_cfg)) drop_live = 1'b0;
    if (sample_cnt > 1 && power_acc != 0) begin
      spread = 128'(peak_mw - floor_mw) * 128'(10000) * 128'(sample_cnt);
      budget = 128'(power_acc) * 128'(10000);
      if (budget <= spread) stab_hold = '0;
      else stab_hold = 14'(128'(10000) - spread / 128'(power_acc));
    end
    if (!s.cpu_active && !s.gpu_active && s.time_ms > 32'(grace_cfg))
      r.health = sphm_pkg::HEALTH_FAILED;
    else if (corr_seen) r.health = sphm_pkg::HEALTH_UNSTABLE;
    else if (drop_cnt > marginal_cfg) r.health = sphm_pkg::HEALTH_MARGINAL;
    else r.health = sphm_pkg::HEALTH_OK;
    last_total = total;
    last_err_sum = err_sum;
    r.total_power_mw = total;
    r.drop_events = drop_cnt;
    r.largest_drop_mw = worst_drop;
    r.errors_correlated = corr_seen;
    r.stability_centi_pct = stab_hold;
    r.stop_request = stop_cfg && (s.cpu_errors != 0 || s.gpu_errors != 0);
  endtask

  task automatic compare_status(input status_t want, input status_t got);
    if (got.total_power_mw !== want.total_power_mw) begin
      $error("total_power_mw: expected %0d, got %0d", want.total_power_mw, got.total_power_mw);
      fail_count++;
    end
    if (got.drop_events !== want.drop_events) begin
      $error("drop_events: expected %0d, got %0d", want.drop_events, got.drop_events);
      fail_count++;
    end
    if (got.largest_drop_mw !== want.largest_drop_mw) begin
      $error("largest_drop_mw: expected %0d, got %0d", want.largest_drop_mw,
             got.largest_drop_mw);
      fail_count++;
    end
    if (got.errors_correlated !== want.errors_correlated) begin
      $error("errors_correlated: expected %0d, got %0d", want.errors_correlated,
             got.errors_correlated);
      fail_count++;
    end
    if (got.stability_centi_pct !== want.stability_centi_pct) begin
      $error("stability_centi_pct: expected %0d, got %0d", want.stability_centi_pct,
             got.stability_centi_pct);
      fail_count++;
    end
    if (got.health !== want.health) begin
      $error("health: expected %0d, got %0d", want.health, got.health);
      fail_count++;
    end
    if (got.stop_request !== want.stop_request) begin
      $error("stop_request: expected %0d, got %0d", want.stop_request, got.stop_request);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    status_t got;
    status_t predicted;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.total_power_mw = m_tdata[20:0];
        got.drop_events = m_tdata[36:21];
        got.largest_drop_mw = m_tdata[57:37];
        got.errors_correlated = m_tdata[58];
        got.stability_centi_pct = m_tdata[72:59];
        got.health = sphm_pkg::health_t'(m_tdata[74:73]);
        got.stop_request = m_tdata[75];
        if (pending_status.size() == 0) begin
          $error("result arrived with no sample waiting for it");
          fail_count++;
        end else begin
          compare_status(pending_status.pop_front(), got);
        end
      end
      if (s_tvalid && s_tready) begin
        judge_sample(cur_sample, predicted);
        pending_status.push_back(cur_known ? cur_want : predicted);
      end
    end
  end

  always @(negedge clk) m_tready = calm || ($urandom_range(0, 99) >= 26);

  task automatic send_sample(input sample_t s, input logic known, input status_t want);
    if (!calm && $urandom_range(0, 99) < 26) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 70)) @(negedge clk);
    end
    cur_sample = s;
    cur_known = known;
    cur_want = want;
    s_tuser = s.clear;
    s_tdata = {6'b0, s.gpu_active, s.cpu_active, s.gpu_errors, s.cpu_errors,
               s.gpu_power_mw, s.cpu_power_mw, s.time_ms};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sphm_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      sphm_pkg::REG_DROP_PCT: pct_cfg = val[6:0];
      sphm_pkg::REG_WINDOW:   window_cfg = val;
      sphm_pkg::REG_MARGINAL: marginal_cfg = val;
      sphm_pkg::REG_GRACE:    grace_cfg = val;
      sphm_pkg::REG_STOP_EN:  stop_cfg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic drain();
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic logic [19:0] clamp_mw(input int unsigned v);
    return (v > 32'h000F_FFFF) ? 20'hFFFFF : 20'(v);
  endfunction

  // Mostly plausible polling sessions: rising time, power near a baseline with occasional
  // drops, zero readings and spikes, and slowly growing error counts.
  task automatic make_sample(output sample_t s);
    int unsigned shape;
    int unsigned scale;
    s = '0;
    if ($urandom_range(0, 99) < 8) begin
      s.clear = 1'($urandom);
      s.time_ms = $urandom;
      s.cpu_power_mw = 20'($urandom);
      s.gpu_power_mw = 20'($urandom);
      s.cpu_errors = 16'($urandom);
      s.gpu_errors = 16'($urandom);
      s.cpu_active = 1'($urandom);
      s.gpu_active = 1'($urandom);
      return;
    end
    if ($urandom_range(0, 29) == 0) begin
      s.clear = 1'b1;
      sess_time = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                               : $urandom_range(0, 500);
      sess_base_cpu = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h000F_FFFF)
                                                   : $urandom_range(100, 60000);
      sess_base_gpu = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h000F_FFFF)
                                                   : $urandom_range(100, 60000);
      sess_cpu_err = 16'($urandom_range(0, 3));
      sess_gpu_err = 16'($urandom_range(0, 3));
    end else begin
      sess_time = sess_time + (($urandom_range(0, 9) == 0) ? $urandom_range(1000, 70000)
                                                           : $urandom_range(0, 600));
    end
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      scale = $urandom_range(0, 95);
      s.cpu_power_mw = clamp_mw(sess_base_cpu * scale / 100);
      s.gpu_power_mw = clamp_mw(sess_base_gpu * scale / 100);
    end else if (shape < 16) begin
      s.cpu_power_mw = '0;
      s.gpu_power_mw = '0;
    end else if (shape < 20) begin
      s.cpu_power_mw = clamp_mw(sess_base_cpu * 2);
      s.gpu_power_mw = clamp_mw(sess_base_gpu * 2);
    end else begin
      s.cpu_power_mw = clamp_mw(sess_base_cpu + $urandom_range(0, sess_base_cpu / 16)
                                - sess_base_cpu / 32);
      s.gpu_power_mw = clamp_mw(sess_base_gpu + $urandom_range(0, sess_base_gpu / 16)
                                - sess_base_gpu / 32);
    end
    if ($urandom_range(0, 4) == 0)
      sess_cpu_err = (sess_cpu_err > 16'hFFFC) ? 16'hFFFF
                                               : sess_cpu_err + 16'($urandom_range(1, 3));
    if ($urandom_range(0, 4) == 0)
      sess_gpu_err = (sess_gpu_err > 16'hFFFC) ? 16'hFFFF
                                               : sess_gpu_err + 16'($urandom_range(1, 3));
    s.time_ms = sess_time;
    s.cpu_errors = sess_cpu_err;
    s.gpu_errors = sess_gpu_err;
    if ($urandom_range(0, 9) == 0) begin
      s.cpu_active = 1'($urandom);
      s.gpu_active = 1'($urandom);
    end else begin
      s.cpu_active = 1'b1;
      s.gpu_active = 1'b1;
    end
  endtask

  initial begin
    sample_t smp;
    pct_cfg = sphm_pkg::PCT_RESET;
    window_cfg = sphm_pkg::WINDOW_RESET;
    marginal_cfg = sphm_pkg::MARGINAL_RESET;
    grace_cfg = sphm_pkg::GRACE_RESET;
    stop_cfg = 1'b0;
    clear_session();
    sess_time = '0;
    sess_base_cpu = 1000;
    sess_base_gpu = 1000;
    sess_cpu_err = '0;
    sess_gpu_err = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      send_sample(directed[i].smp, directed[i].known, directed[i].want);
    s_tvalid = 1'b0;

    settings[4][0] = 16'($urandom_range(0, 100));
    settings[4][1] = 16'($urandom);
    settings[4][2] = 16'($urandom_range(0, 20));
    settings[4][3] = 16'($urandom);
    settings[4][4] = 16'($urandom_range(0, 1));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (8) @(posedge clk);
      write_reg(sphm_pkg::REG_DROP_PCT, settings[p][0]);
      write_reg(sphm_pkg::REG_WINDOW, settings[p][1]);
      write_reg(sphm_pkg::REG_MARGINAL, settings[p][2]);
      write_reg(sphm_pkg::REG_GRACE, settings[p][3]);
      write_reg(sphm_pkg::REG_STOP_EN, settings[p][4]);
      calm = (p == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        make_sample(smp);
        send_sample(smp, 1'b0, UNCHECKED);
      end
      s_tvalid = 1'b0;
    end

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: supply_power_health_monitor.f
src/sphm_pkg.sv
src/supply_power_health_monitor.sv
sim/tb_top.sv
